/* rtl/lorenz_euler_step_core_assert.svh */
// Assertion macros for the Lorenz Euler step core.
// Included by the checker; needs clk and arst_n in the including scope.
`ifndef LORENZ_EULER_STEP_CORE_ASSERT_SVH
`define LORENZ_EULER_STEP_CORE_ASSERT_SVH

// antecedent and consequent on the same edge
`define LES_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent on the edge after the antecedent
`define LES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/les_pkg.sv */
// Shared constants, phase codes and control struct for the Lorenz Euler step core.
// No dependencies.
package les_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 24;
	localparam int STEP_FRAC       = 24;
	localparam int TSTEP_W         = 24;
	localparam int IO_W            = 32;

	localparam logic [TSTEP_W-1:0] TIME_STEP_RST = 24'd167772;

	// APB register file: one word register
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_TIME_STEP = 1'b0;

	localparam logic [1:0] OP_STEP   = 2'd0;
	localparam logic [1:0] OP_LOAD_X = 2'd1;
	localparam logic [1:0] OP_LOAD_Y = 2'd2;
	localparam logic [1:0] OP_LOAD_Z = 2'd3;

	// sequencer phases; each of PH_XZ to PH_LZ issues one multiply
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_XZ   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_XY   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_BZ   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_HX   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LX   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_HY   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_LY   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_HZ   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_LZ   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_FIN  = 4'd9;
	localparam logic [PHASE_W-1:0] PH_IDLE = 4'd15;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               mul_en;
		logic               finish;
		logic               load_en;
		logic [1:0]         load_sel;
	} les_ctrl_t;

endpackage

/* rtl/les_apb.sv */
// APB-style configuration register: the Euler timestep.
// Depends on les_pkg.
module les_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [les_pkg::APB_AW-1:0]   paddr,
	input  logic [les_pkg::APB_DW-1:0]   pwdata,
	output logic [les_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output logic [les_pkg::TSTEP_W-1:0]  time_step
);
	import les_pkg::*;

	logic [TSTEP_W-1:0] time_step_q;
	logic               hit;
	logic               wr_en;

	assign pready = 1'b1;
	assign hit    = (paddr[APB_AW-1:2] == REG_TIME_STEP);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
		end else if (wr_en) begin
			time_step_q <= pwdata[TSTEP_W-1:0];
		end
	end

	assign prdata    = hit ? APB_DW'(time_step_q) : '0;
	assign time_step = time_step_q;

endmodule

/* rtl/les_mul.sv */
// Shared signed multiplier with registered product.
// No dependencies.
module les_mul #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= a * b;
		end
	end

endmodule

/* rtl/les_ctrl.sv */
// Step sequencer and handshake control for the Lorenz Euler step core.
// Depends on les_pkg.
module les_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         op,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output les_pkg::les_ctrl_t ctrl
);
	import les_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_d;
	logic               out_valid_q;
	logic               accept;
	logic               out_free;
	logic               finish;

	assign in_ready = (phase_q == PH_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (phase_q == PH_FIN) && out_free;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (accept && op == OP_STEP) begin
					phase_d = PH_XZ;
				end
			end
			PH_FIN: begin
				if (out_free) begin
					phase_d = PH_IDLE;
				end
			end
			PH_XZ, PH_XY, PH_BZ, PH_HX, PH_LX, PH_HY, PH_LY, PH_HZ, PH_LZ: begin
				phase_d = phase_q + PHASE_W'(1);
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		ctrl.phase    = phase_q;
		ctrl.mul_en   = (phase_q != PH_FIN) && (phase_q != PH_IDLE);
		ctrl.finish   = finish;
		ctrl.load_en  = accept && (op != OP_STEP);
		ctrl.load_sel = op;
	end

endmodule

/* rtl/les_dp.sv */
// Datapath: point registers, derivatives and step accumulation around one multiplier.
// Depends on les_pkg and les_mul.
module les_dp #(
	parameter int COORD_WIDTH = les_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = les_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  les_pkg::les_ctrl_t                 ctrl,
	input  logic signed [les_pkg::IO_W-1:0]    load_value,
	input  logic [les_pkg::TSTEP_W-1:0]        time_step,
	output logic signed [les_pkg::IO_W-1:0]    next_x,
	output logic signed [les_pkg::IO_W-1:0]    next_y,
	output logic signed [les_pkg::IO_W-1:0]    next_z
);
	import les_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	// derivative width: product term or 28*x, plus headroom for two adds
	localparam int PW = (2 * CW - F > CW + 5) ? 2 * CW - F : CW + 5;
	localparam int DW = PW + 2;
	localparam int HW = DW - STEP_FRAC;
	localparam int M1 = (CW > HW) ? CW : HW;
	localparam int M2 = (M1 > STEP_FRAC + 1) ? M1 : STEP_FRAC + 1;
	localparam int MW = (M2 > F + 3) ? M2 : F + 3;
	localparam int SW = DW + 1;

	localparam logic signed [CW-1:0]   INIT_Q = CW'(((64'd3 << F) + 64'd2) / 64'd5);
	localparam logic signed [MW-1:0]   BETA_Q = MW'(((64'd8 << F) + 64'd1) / 64'd3);
	localparam logic signed [CW-1:0]   C_MAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0]   C_MIN  = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [2*MW-1:0] RND_F  = (2*MW)'(64'd1 << (F - 1));
	localparam logic signed [2*MW-1:0] RND_S  = (2*MW)'(64'd1 << (STEP_FRAC - 1));

	function automatic logic signed [CW-1:0] sat_sum(input logic signed [SW-1:0] v);
		logic [SW-CW:0] hi_bits;
		hi_bits = v[SW-1:CW-1];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[CW-1:0];
		end else if (v[SW-1]) begin
			return C_MIN;
		end else begin
			return C_MAX;
		end
	endfunction

	function automatic logic signed [CW-1:0] sat_load(input logic signed [IO_W-1:0] v);
		logic [IO_W-CW:0] hi_bits;
		hi_bits = v[IO_W-1:CW-1];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[CW-1:0];
		end else if (v[IO_W-1]) begin
			return C_MIN;
		end else begin
			return C_MAX;
		end
	endfunction

	logic signed [CW-1:0]   point_x_q, point_y_q, point_z_q;
	logic signed [DW-1:0]   dx_q, dy_q, dz_q, acc_q;
	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] prod;
	logic signed [2*MW-1:0] prod_rf, prod_rs;
	logic signed [DW-1:0]   prod_f, step_lo;
	logic signed [DW-1:0]   diff, dx_init, dy_init;
	logic signed [CW-1:0]   cur, new_c, ld_val;
	logic signed [SW-1:0]   sum;

	// operand select per phase
	always_comb begin
		unique case (ctrl.phase)
			PH_XZ: begin
				mul_a = MW'(point_x_q);
				mul_b = MW'(point_z_q);
			end
			PH_XY: begin
				mul_a = MW'(point_x_q);
				mul_b = MW'(point_y_q);
			end
			PH_BZ: begin
				mul_a = BETA_Q;
				mul_b = MW'(point_z_q);
			end
			PH_HX: begin
				mul_a = MW'(dx_q >>> STEP_FRAC);
				mul_b = MW'(time_step);
			end
			PH_LX: begin
				mul_a = MW'(dx_q[STEP_FRAC-1:0]);
				mul_b = MW'(time_step);
			end
			PH_HY: begin
				mul_a = MW'(dy_q >>> STEP_FRAC);
				mul_b = MW'(time_step);
			end
			PH_LY: begin
				mul_a = MW'(dy_q[STEP_FRAC-1:0]);
				mul_b = MW'(time_step);
			end
			PH_HZ: begin
				mul_a = MW'(dz_q >>> STEP_FRAC);
				mul_b = MW'(time_step);
			end
			PH_LZ: begin
				mul_a = MW'(dz_q[STEP_FRAC-1:0]);
				mul_b = MW'(time_step);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	les_mul #(
		.W (MW)
	) u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// round half up: Q product back to FRAC_BITS, h*lo back to integer LSB
	assign prod_rf = (prod + RND_F) >>> F;
	assign prod_rs = (prod + RND_S) >>> STEP_FRAC;
	assign prod_f  = prod_rf[DW-1:0];
	assign step_lo = prod_rs[DW-1:0];

	assign diff    = DW'(point_y_q) - DW'(point_x_q);
	assign dx_init = (diff <<< 3) + (diff <<< 1);
	assign dy_init = (DW'(point_x_q) <<< 5) - (DW'(point_x_q) <<< 2) - DW'(point_y_q);

	always_comb begin
		priority if (ctrl.phase == PH_HY) begin
			cur = point_x_q;
		end else if (ctrl.phase == PH_HZ) begin
			cur = point_y_q;
		end else begin
			cur = point_z_q;
		end
	end

	// old coordinate + h*hi + round(h*lo)
	assign sum    = SW'(cur) + SW'(acc_q) + SW'(step_lo);
	assign new_c  = sat_sum(sum);
	assign ld_val = sat_load(load_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= INIT_Q;
			point_y_q <= INIT_Q;
			point_z_q <= INIT_Q;
		end else if (ctrl.load_en) begin
			unique case (ctrl.load_sel)
				OP_LOAD_X: begin
					point_x_q <= ld_val;
				end
				OP_LOAD_Y: begin
					point_y_q <= ld_val;
				end
				OP_LOAD_Z: begin
					point_z_q <= ld_val;
				end
				OP_STEP: begin
				end
			endcase
		end else if (ctrl.phase == PH_HY) begin
			point_x_q <= new_c;
		end else if (ctrl.phase == PH_HZ) begin
			point_y_q <= new_c;
		end else if (ctrl.finish) begin
			point_z_q <= new_c;
		end
	end

	// derivatives use old coordinates only; all settled before x is written
	always_ff @(posedge clk) begin
		unique case (ctrl.phase)
			PH_XZ: begin
				dx_q <= dx_init;
				dy_q <= dy_init;
			end
			PH_XY: begin
				dy_q <= dy_q - prod_f;
			end
			PH_BZ: begin
				dz_q <= prod_f;
			end
			PH_HX: begin
				dz_q <= dz_q - prod_f;
			end
			PH_LX, PH_LY, PH_LZ: begin
				acc_q <= prod[DW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			next_x <= IO_W'(point_x_q);
			next_y <= IO_W'(point_y_q);
			next_z <= IO_W'(new_c);
		end
	end

endmodule

/* rtl/lorenz_euler_step_core.sv */
// Lorenz attractor generator advanced by explicit Euler steps (sigma 10, rho 28,
// beta 8/3), signed Q8.24 coordinates. Depends on les_pkg, les_apb, les_ctrl, les_dp.
//
// Input channel (in_valid/in_ready, op, load_value): op step advances the point
// by one timestep and yields one result item; op load x/y/z writes one coordinate
// and yields nothing.
// Output channel (out_valid/out_ready, next_x/y/z): the new point, saturated.
// Config: APB register 0 (byte 0) holds the timestep h, unsigned Q0.24.
//
// A step runs ten phases on one shared signed multiplier: x*z, x*y, beta*z,
// then h times the high and low halves of each derivative. The result item is
// valid as the sequencer returns to idle; in_ready stays low from acceptance
// until then, so a step is finished before the next item is taken. Loads go at
// one per cycle while no step runs. If the receiver stalls, the finished result
// waits in the output register and the block still takes loads and a next step;
// that step holds in its last phase until the output register is free.
// Reset: point (0.6, 0.6, 0.6), h = 0.01, no result pending.
module lorenz_euler_step_core #(
	parameter int COORD_WIDTH = les_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = les_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [les_pkg::APB_AW-1:0]       paddr,
	input  logic [les_pkg::APB_DW-1:0]       pwdata,
	output logic [les_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	// input items
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic signed [les_pkg::IO_W-1:0]  load_value,
	// result items
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [les_pkg::IO_W-1:0]  next_x,
	output logic signed [les_pkg::IO_W-1:0]  next_y,
	output logic signed [les_pkg::IO_W-1:0]  next_z
);
	import les_pkg::*;

	logic [TSTEP_W-1:0] time_step;
	les_ctrl_t          ctrl;

	les_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.time_step (time_step)
	);

	// phase sequencer; holds in the last phase while the output is occupied
	les_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.ctrl      (ctrl)
	);

	// point, derivative and step registers around the shared multiplier
	les_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.load_value (load_value),
		.time_step  (time_step),
		.next_x     (next_x),
		.next_y     (next_y),
		.next_z     (next_z)
	);

endmodule

/* rtl/les_checker.sv */
// Port-level checks for the Lorenz Euler step core, bound to the top level.
// Depends on les_pkg and lorenz_euler_step_core_assert.svh.
`include "lorenz_euler_step_core_assert.svh"

module les_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  op,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [les_pkg::IO_W-1:0]    next_x,
	input logic [les_pkg::IO_W-1:0]    next_y,
	input logic [les_pkg::IO_W-1:0]    next_z
);
	import les_pkg::*;

	// a step keeps the block busy
	`LES_ASSERT_NEXT(a_step_busy, in_valid && in_ready && op == OP_STEP, !in_ready, "step accepted but still ready")

	// a load never makes a result
	`LES_ASSERT_NEXT(a_load_silent, in_valid && in_ready && op != OP_STEP && !out_valid, !out_valid, "load produced a result")

	// a result appears only as the sequencer goes idle
	`LES_ASSERT_SAME(a_result_idle, $rose(out_valid), in_ready, "result while sequencer busy")

	// stalled result holds
	`LES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_x) && $stable(next_y) && $stable(next_z), "stalled result changed")

endmodule

bind lorenz_euler_step_core les_checker u_les_checker (.*);

/* verif/lorenz_euler_step_core_tb.sv */
// Testbench for lorenz_euler_step_core: random and directed step/load items,
// APB timestep changes, backpressure. Needs les_pkg and the core RTL only.
`timescale 1ns / 1ps

module lorenz_euler_step_core_tb;
	import les_pkg::*;

	// Q8.24 constants of the attractor
	localparam longint BETA_Q     = 44739243;     // round(8/3 * 2^24)
	localparam longint POINT_RST  = 10066330;     // round(0.6 * 2^24)
	localparam longint COORD_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN  = -64'sd2147483648;
	localparam longint ROUND_HALF = 64'sd8388608; // half an LSB at 24 fraction bits
	localparam int     FRAC       = 24;

	localparam int HOLD_CYCLES = 300;  // long receiver stall for the backpressure test
	localparam int IDLE_LIMIT  = 2000; // cycles with no handshake before giving up
	localparam int SETTLE      = 12;   // block latency plus margin

	typedef struct {
		logic signed [IO_W-1:0] x;
		logic signed [IO_W-1:0] y;
		logic signed [IO_W-1:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic signed [IO_W-1:0] load_value;
	logic out_valid;
	logic out_ready;
	logic signed [IO_W-1:0] next_x;
	logic signed [IO_W-1:0] next_y;
	logic signed [IO_W-1:0] next_z;

	// predictor state: current point and timestep, as the block should hold them
	longint cur_x;
	longint cur_y;
	longint cur_z;
	logic [TSTEP_W-1:0] h_cfg;

	// points the block still owes us, oldest first
	point_t pending_points[$];

	// shared control between the stimulus and the receiver
	bit burst_mode;
	bit hold_req;

	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned points_checked;
	int unsigned h_settings;
	int unsigned holds_done;
	int unsigned idle_cycles;

	lorenz_euler_step_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.load_value (load_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_x     (next_x),
		.next_y     (next_y),
		.next_z     (next_z)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor arithmetic. Everything is done in 64-bit signed so the
	// wide derivatives never wrap; >>> on a signed value is a floor shift.
	// ------------------------------------------------------------------

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Q8.24 times Q8.24, rounded half up back to 24 fraction bits
	function automatic longint round_mul(input longint a, input longint b);
		return (a * b + ROUND_HALF) >>> FRAC;
	endfunction

	// h * d, rounded half up; d split into high and low parts so h*d cannot overflow
	function automatic longint scale_by_h(input longint d);
		longint hi;
		longint lo;
		longint hv;
		hi = d >>> FRAC;
		lo = d & 64'sh0000_0000_00FF_FFFF;
		hv = longint'({40'd0, h_cfg});
		return hi * hv + ((lo * hv + ROUND_HALF) >>> FRAC);
	endfunction

	// Apply one accepted item to the predicted point; a step also queues the
	// new point as an expected result. Derivatives use only the old point.
	function automatic void advance_point(input logic [1:0] code,
			input logic signed [IO_W-1:0] value);
		longint v;
		longint dx;
		longint dy;
		longint dz;
		point_t nxt;
		v = clamp_coord(longint'(value));
		case (code)
			OP_LOAD_X: cur_x = v;
			OP_LOAD_Y: cur_y = v;
			OP_LOAD_Z: cur_z = v;
			default: begin
				dx = 10 * (cur_y - cur_x);
				dy = 28 * cur_x - cur_y - round_mul(cur_x, cur_z);
				dz = round_mul(cur_x, cur_y) - round_mul(BETA_Q, cur_z);
				cur_x = clamp_coord(cur_x + scale_by_h(dx));
				cur_y = clamp_coord(cur_y + scale_by_h(dy));
				cur_z = clamp_coord(cur_z + scale_by_h(dz));
				nxt.x = cur_x[IO_W-1:0];
				nxt.y = cur_y[IO_W-1:0];
				nxt.z = cur_z[IO_W-1:0];
				pending_points.push_back(nxt);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender side. Called right after a rising edge; returns right after
	// the edge at which the item was taken, with valid still high so a
	// back-to-back item needs no lowering.
	// ------------------------------------------------------------------

	task automatic send_item(input logic [1:0] code, input logic signed [IO_W-1:0] value);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= code;
		load_value <= value;
		// inputs and outputs only move at rising edges, so the falling edge
		// shows what the next rising edge will see
		@(negedge clk);
		while (in_ready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
		advance_point(code, value);
		items_sent++;
	endtask

	// Stop offering items until every owed point has come back, then let a
	// trailing load finish before anything else touches the block.
	task automatic wait_drain;
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB access: setup cycle, then access cycle. pready is always high.
	// ------------------------------------------------------------------

	task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_TIME_STEP, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic verify_time_step;
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[TSTEP_W-1:0] !== h_cfg) begin
			$error("time_step readback: expected %0d, got %0d", h_cfg, rd[TSTEP_W-1:0]);
			fail_count++;
		end
	endtask

	task automatic set_time_step(input logic [TSTEP_W-1:0] h_new);
		logic [APB_DW-1:0] rd;
		wait_drain();
		apb_access(1'b1, {{(APB_DW-TSTEP_W){1'b0}}, h_new}, rd);
		h_cfg = h_new;
		h_settings++;
		verify_time_step();
	endtask

	// ------------------------------------------------------------------
	// Receiver: per point it draws a random stall (none in burst mode), or one
	// long stall when the backpressure test asks for it.
	// ------------------------------------------------------------------

	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
				holds_done++;
			end else begin
				stall = burst_mode ? 0 : $urandom_range(0, 15);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (out_valid !== 1'b1)
				@(negedge clk);
			@(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: a point taken at the coming rising edge is compared
	// with the oldest prediction.
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic signed [IO_W-1:0] exp_v,
			input logic signed [IO_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		point_t exp_p;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_points.size() == 0) begin
				$error("next point %0d %0d %0d with none expected", next_x, next_y, next_z);
				fail_count++;
			end else begin
				exp_p = pending_points.pop_front();
				check_field("next_x", exp_p.x, next_x);
				check_field("next_y", exp_p.y, next_y);
				check_field("next_z", exp_p.z, next_z);
				points_checked++;
			end
		end
	end

	// Watchdog: a run that stops moving items is a hang.
	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset timestep reads back, and the first step starts from (0.6, 0.6, 0.6)
	task automatic test_reset_state;
		verify_time_step();
		send_item(OP_STEP, '0);
	endtask

	// full-scale corners of the load field; steps from them must saturate
	task automatic test_load_extremes;
		send_item(OP_LOAD_X, 32'sh7FFF_FFFF);
		send_item(OP_LOAD_Y, 32'sh8000_0000);
		send_item(OP_LOAD_Z, 32'sh0000_0000);
		send_item(OP_STEP, '0);
		send_item(OP_LOAD_X, 32'sh8000_0000);
		send_item(OP_LOAD_Y, 32'sh7FFF_FFFF);
		send_item(OP_LOAD_Z, 32'sh7FFF_FFFF);
		send_item(OP_STEP, '0);
		send_item(OP_LOAD_X, 32'sh8000_0000);
		send_item(OP_LOAD_Y, 32'sh8000_0000);
		send_item(OP_LOAD_Z, 32'sh8000_0000);
		send_item(OP_STEP, '0);
		send_item(OP_LOAD_X, 32'sh7FFF_FFFF);
		send_item(OP_LOAD_Y, 32'sh7FFF_FFFF);
		send_item(OP_LOAD_Z, 32'sh7FFF_FFFF);
		send_item(OP_STEP, '0);
		// load_value is don't-care on a step
		send_item(OP_STEP, 32'shFFFF_FFFF);
	endtask

	// zero timestep: the point comes back unchanged
	task automatic test_zero_step;
		set_time_step('0);
		send_item(OP_LOAD_X, 32'sh0A00_0000);
		send_item(OP_STEP, 32'sh5555_5555);
		send_item(OP_STEP, 32'shAAAA_AAAA);
	endtask

	// largest timestep, just under 1.0
	task automatic test_max_step;
		set_time_step({TSTEP_W{1'b1}});
		send_item(OP_LOAD_Z, -32'sd16777216);
		send_item(OP_STEP, '0);
		send_item(OP_STEP, '0);
	endtask

	// Mostly steps along the attractor from loaded points in the usual range
	// (+-50), with full-range loads and stray steps mixed in. Each phase
	// uses a different timestep.
	task automatic test_random_walk;
		logic [TSTEP_W-1:0] h_new;
		logic [1:0] code;
		logic signed [IO_W-1:0] value;
		int unsigned pick;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: h_new = TIME_STEP_RST;
				1: h_new = TSTEP_W'($urandom_range(1, 838860));   // up to 0.05
				2: h_new = TSTEP_W'($urandom);                    // anywhere in [0, 1)
				3: h_new = 24'd1;                                 // smallest nonzero
				default: h_new = TSTEP_W'($urandom_range(0, 335544));
			endcase
			set_time_step(h_new);
			for (int n = 0; n < 270; n++) begin
				if (n % 40 == 0)
					burst_mode = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					code  = OP_STEP;
					value = $urandom;
				end else if (pick < 88) begin
					code  = 2'($urandom_range(1, 3));
					value = $signed($urandom_range(0, 1677721600)) - 32'sd838860800;
				end else begin
					code  = 2'($urandom_range(1, 3));
					value = $urandom;
				end
				send_item(code, value);
			end
			burst_mode = 1'b0;
		end
	endtask

	// receiver stalls for a long stretch while steps keep coming, so the
	// output register fills and the block stops taking input; then the
	// sender waits until everything has drained
	task automatic test_backpressure;
		set_time_step(TIME_STEP_RST);
		hold_req   = 1'b1;
		burst_mode = 1'b1;
		for (int n = 0; n < 16; n++)
			send_item((n % 4 == 3) ? OP_LOAD_Y : OP_STEP, 32'sh0100_0000);
		burst_mode = 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		op         = OP_STEP;
		load_value = '0;
		burst_mode = 1'b0;
		hold_req   = 1'b0;
		fail_count = 0;
		items_sent = 0;
		points_checked = 0;
		h_settings = 0;
		holds_done = 0;
		idle_cycles = 0;
		cur_x = POINT_RST;
		cur_y = POINT_RST;
		cur_z = POINT_RST;
		h_cfg = TIME_STEP_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_load_extremes();
		test_zero_step();
		test_max_step();
		test_random_walk();
		test_backpressure();

		wait_drain();
		repeat (SETTLE) @(posedge clk);
		if (pending_points.size() != 0) begin
			$error("%0d expected points never arrived", pending_points.size());
			fail_count++;
		end

		$display("summary: %0d items in, %0d points checked, %0d timestep writes",
			items_sent, points_checked, h_settings);
		$display("summary: saturating loads, zero and full-scale timestep, %0d long stalls",
			holds_done);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
